>>> src/mhd_pkg.sv
// Shared types and constants for the module header deframer.
package mhd_pkg;

    // Header geometry
    localparam int unsigned HDR_WORDS = 24;
    localparam int unsigned HDR_LAST  = HDR_WORDS - 1;
    localparam int unsigned IDX_W     = 5;
    localparam int unsigned CNT_W     = 15;
    localparam int unsigned SL_W      = 32;

    // Stream constants
    localparam logic [15:0] SYNC_WORD    = 16'hFC4A;
    localparam logic [15:0] CHECK_XOR    = 16'hFFFF;
    localparam logic [15:0] BYTE_LO_MASK = 16'h00FF;
    localparam logic [15:0] BYTE_HI_MASK = 16'hFF00;

    // Offsets removed from the size and name fields of the header
    localparam logic signed [15:0] WCNT_BIAS = 16'sd24;
    localparam logic signed [15:0] NCNT_BIAS = 16'sd23;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HDR_LAST);
    localparam logic [IDX_W-1:0] IDX_SIZE = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_NAME = IDX_W'(7);

    // Controller states
    typedef enum logic [3:0] {
        S_SEARCH,
        S_HEADER,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_WR,
        S_MODULE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_COPY_RD,
        S_COPY_WR
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic in_fire;     // an input word is accepted
        logic start_sync;  // sync word found while searching
        logic hdr_wr;      // store input word into header
        logic payload;     // pass input word as payload
        logic chk_pass;    // header accepted, load module counters
        logic scan_init;   // header rejected, start rescan
        logic rd_en;       // read header store at index
        logic emit_wr;     // emit header word from read data
        logic scan_hit;    // sync found at index during rescan
        logic scan_next;   // advance rescan
        logic scan_miss;   // rescan found no sync
        logic copy_wr;     // move one header word down
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_is_sync;
        logic hdr_full;
        logic chk_ok;
        logic out_free;
        logic idx_last;
        logic rd_is_sync;
        logic payload_end;
    } status_t;

endpackage

>>> src/mhd_datapath.sv
// Datapath: header store, checks, counters and output register.
module mhd_datapath
    import mhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] s_tdata,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [15:0] m_tdata,   // word_out
    output logic        m_tlast,   // module_last
    output logic [2:0]  m_tuser    // module_first, name_word, run_last
);

    // Header store
    logic [15:0] mem [HDR_WORDS];
    logic [15:0] rdata_reg;

    // Control counters
    logic [IDX_W-1:0] hcount_reg, hcount_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pleft_reg, pleft_next;
    logic [CNT_W-1:0] ncnt_reg, ncnt_next;
    logic             ndone_reg, ndone_next;
    logic [SL_W-1:0]  sleft_reg, sleft_next;

    // Payload registers
    logic [15:0] xor_reg, xor_next;
    logic [15:0] prefix_reg, prefix_next;
    logic [15:0] h3_reg, h7_reg;

    // Output register
    logic        ovalid_reg, ovalid_next;
    logic [15:0] odata_reg;
    logic        olast_reg, ofirst_reg, oname_reg, orun_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [15:0]      mem_wd;
    logic             out_free;
    logic             out_load;

    logic signed [15:0] wcnt_s, ncnt_s;
    logic               wcnt_le0, ncnt_neg;
    logic               fits_w, fits_n;
    logic [CNT_W-1:0]   pl_dec, nc_dec;
    logic               nm;
    logic [SL_W:0]      sl_sum;

    // Header size and name offset, byte swapped and halved
    assign wcnt_s   = $signed({1'b0, h3_reg[7:0], h3_reg[15:9]}) - WCNT_BIAS;
    assign ncnt_s   = $signed({1'b0, h7_reg[7:0], h7_reg[15:9]}) - NCNT_BIAS;
    assign wcnt_le0 = wcnt_s[15] || (wcnt_s == 16'sd0);
    assign ncnt_neg = ncnt_s[15];
    assign fits_w   = wcnt_le0 || ({17'd0, wcnt_s[14:0]} <= sleft_reg);
    assign fits_n   = ncnt_neg || (ncnt_s == 16'sd0)
                      || ({17'd0, ncnt_s[14:0]} <= sleft_reg);

    // Payload word bookkeeping
    assign pl_dec = (pleft_reg != '0) ? pleft_reg - CNT_W'(1) : '0;
    assign nc_dec = (ncnt_reg != '0) ? ncnt_reg - CNT_W'(1) : '0;
    assign nm     = !ndone_reg && (nc_dec == '0);

    assign out_free = !ovalid_reg || m_tready;
    assign out_load = cmd.payload || cmd.emit_wr;

    // Words given back to the stream count on a rescan hit
    assign sl_sum = {1'b0, sleft_reg} + (SL_W+1)'(IDX_LAST - idx_reg);

    // Status
    assign st.in_is_sync  = (s_tdata == SYNC_WORD);
    assign st.hdr_full    = (hcount_reg == IDX_LAST);
    assign st.chk_ok      = fits_w && fits_n && (xor_reg == CHECK_XOR);
    assign st.out_free    = out_free;
    assign st.idx_last    = (idx_reg == IDX_LAST);
    assign st.rd_is_sync  = (rdata_reg == SYNC_WORD);
    assign st.payload_end = (pl_dec == '0);

    // Store write port
    always_comb
    begin
        mem_we = cmd.start_sync || cmd.hdr_wr || cmd.copy_wr;
        mem_wa = cmd.start_sync ? '0 : hcount_reg;
        mem_wd = cmd.copy_wr ? rdata_reg : s_tdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    // Size and name words follow every store write
    always_ff @(posedge clk)
    begin
        if (mem_we && (mem_wa == IDX_SIZE))
        begin
            h3_reg <= mem_wd;
        end
        if (mem_we && (mem_wa == IDX_NAME))
        begin
            h7_reg <= mem_wd;
        end
    end

    // Next-state logic for counters and XOR
    always_comb
    begin
        hcount_next = hcount_reg;
        idx_next    = idx_reg;
        pleft_next  = pleft_reg;
        ncnt_next   = ncnt_reg;
        ndone_next  = ndone_reg;
        sleft_next  = sleft_reg;
        xor_next    = xor_reg;
        prefix_next = prefix_reg;

        if (cmd.start_sync)
        begin
            hcount_next = IDX_W'(1);
            xor_next    = s_tdata;
        end
        if (cmd.hdr_wr || cmd.copy_wr)
        begin
            hcount_next = hcount_reg + IDX_W'(1);
        end
        if (cmd.hdr_wr)
        begin
            xor_next = xor_reg ^ s_tdata;
        end
        if (cmd.chk_pass)
        begin
            hcount_next = '0;
            idx_next    = '0;
            pleft_next  = wcnt_le0 ? CNT_W'(1) : wcnt_s[CNT_W-1:0];
            ndone_next  = ncnt_neg;
            ncnt_next   = ncnt_neg ? '0 : ncnt_s[CNT_W-1:0];
        end
        if (cmd.scan_init)
        begin
            idx_next    = IDX_W'(1);
            prefix_next = SYNC_WORD;
        end
        if (cmd.scan_next)
        begin
            idx_next    = idx_reg + IDX_W'(1);
            prefix_next = prefix_reg ^ rdata_reg;
        end
        if (cmd.scan_hit)
        begin
            hcount_next = '0;
            xor_next    = xor_reg ^ prefix_reg;
            sleft_next  = sl_sum[SL_W] ? '1 : sl_sum[SL_W-1:0];
        end
        if (cmd.scan_miss)
        begin
            hcount_next = '0;
        end
        if (cmd.emit_wr || cmd.copy_wr)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.payload)
        begin
            pleft_next = pl_dec;
            if (!ndone_reg)
            begin
                ncnt_next = nc_dec;
                if (nm && (((s_tdata & BYTE_LO_MASK) == '0)
                           || ((s_tdata & BYTE_HI_MASK) == '0)))
                begin
                    ndone_next = 1'b1;
                end
            end
        end
        if (cmd.in_fire)
        begin
            sleft_next = (sleft_reg != '0) ? sleft_reg - SL_W'(1) : '0;
        end
        if (cfg_valid)
        begin
            sleft_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcount_reg <= '0;
            idx_reg    <= '0;
            pleft_reg  <= '0;
            ncnt_reg   <= '0;
            ndone_reg  <= 1'b1;
            sleft_reg  <= '1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            hcount_reg <= hcount_next;
            idx_reg    <= idx_next;
            pleft_reg  <= pleft_next;
            ncnt_reg   <= ncnt_next;
            ndone_reg  <= ndone_next;
            sleft_reg  <= sleft_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xor_reg    <= xor_next;
        prefix_reg <= prefix_next;
    end

    // Output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (out_load)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.payload)
        begin
            odata_reg  <= s_tdata;
            ofirst_reg <= 1'b0;
            olast_reg  <= (pl_dec == '0);
            oname_reg  <= nm;
            orun_reg   <= 1'b1;
        end
        else if (cmd.emit_wr)
        begin
            odata_reg  <= rdata_reg;
            ofirst_reg <= (idx_reg == '0);
            olast_reg  <= 1'b0;
            oname_reg  <= 1'b0;
            orun_reg   <= (idx_reg == IDX_LAST);
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tlast  = olast_reg;
    assign m_tuser  = {orun_reg, oname_reg, ofirst_reg};

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten before it was taken");

    a_first_is_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ofirst_reg) |-> (odata_reg == SYNC_WORD))
        else $error("module start marked on a word other than sync");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.hdr_wr || cmd.copy_wr) |-> (hcount_reg <= IDX_LAST))
        else $error("header write beyond store");

endmodule

>>> src/mhd_ctrl.sv
// Controller: sequences search, header collection, checks, emission and rescan.
module mhd_ctrl
    import mhd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SEARCH;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign fire = s_tvalid && s_tready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cmd.in_fire = fire;

        unique case (state_reg)
            S_SEARCH:
            begin
                s_tready = 1'b1;
                if (fire && st.in_is_sync)
                begin
                    cmd.start_sync = 1'b1;
                    state_next     = S_HEADER;
                end
            end
            S_HEADER:
            begin
                s_tready = 1'b1;
                if (fire)
                begin
                    cmd.hdr_wr = 1'b1;
                    if (st.hdr_full)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (st.chk_ok)
                begin
                    cmd.chk_pass = 1'b1;
                    state_next   = S_EMIT_RD;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (st.out_free)
                begin
                    cmd.emit_wr = 1'b1;
                    state_next  = st.idx_last ? S_MODULE : S_EMIT_RD;
                end
            end
            S_MODULE:
            begin
                s_tready = st.out_free;
                if (fire)
                begin
                    cmd.payload = 1'b1;
                    if (st.payload_end)
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (st.rd_is_sync)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = S_COPY_RD;
                end
                else if (st.idx_last)
                begin
                    cmd.scan_miss = 1'b1;
                    state_next    = S_SEARCH;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
            end
            S_COPY_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = st.idx_last ? S_HEADER : S_COPY_RD;
            end
            default:
            begin
                state_next = S_SEARCH;
            end
        endcase
    end

    // Checks
    a_emit_to_module: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_wr && st.idx_last) |=> (state_reg == S_MODULE))
        else $error("header burst did not hand over to payload");

    a_end_to_search: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.payload && st.payload_end) |=> (state_reg == S_SEARCH))
        else $error("module end did not return to search");

endmodule

>>> src/module_header_deframer_unit.sv
// Top level of the module header deframer.
// A payload word is registered onto m_* in the cycle after it is accepted.
// A completed header is checked; an accepted one is sent as 24 header words
// from the header store, then payload runs one word per cycle while the
// output is free. A rejected header is rescanned; on a sync hit its words
// move down before input is taken again. Reset: async active low, returns
// to sync search with stream count all ones; header store contents are kept.
module module_header_deframer_unit
    import mhd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: stream_words
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,    // stream_words
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // word_in
    // output words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // word_out
    output logic        m_tlast,     // module_last
    output logic [2:0]  m_tuser      // module_first, name_word, run_last
);

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    mhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mhd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
